// ----- hw/rtl/pfx_pkg.sv -----
// ----------------------------------------------------------------------------
// pfx_pkg
// Shared types and constants of the postfix expression evaluator.
// ----------------------------------------------------------------------------
package pfx_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_STAR  = 8'd42;
  localparam logic [7:0] CH_SLASH = 8'd47;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } alu_op_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_expr;
  } sym_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               stack_empty;
    logic               underflow_seen;
    logic               overflow_seen;
    logic               div_zero_seen;
  } result_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic div_zero;
  } alu_rsp_t;

endpackage

// ----- hw/rtl/pfx_stack_ram.sv -----
// ----------------------------------------------------------------------------
// pfx_stack_ram
// Operand stack storage with one write port and one registered read port.
// ----------------------------------------------------------------------------
module pfx_stack_ram
  import pfx_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [31:0]       wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [31:0]       rdata
);

  logic [31:0] mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/pfx_alu.sv -----
// ----------------------------------------------------------------------------
// pfx_alu
// Shared arithmetic unit: registered add, subtract and multiply, and signed
// division by a restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pfx_alu
  import pfx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  alu_req_t    req,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output alu_rsp_t    rsp,
  output logic [31:0] result
);

  typedef enum logic [1:0] {
    A_IDLE,
    A_DIV,
    A_FIX
  } alu_state_t;

  alu_state_t  state;
  logic [31:0] quo;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic        neg;
  logic [4:0]  step;
  logic [32:0] trial;
  logic [32:0] diff;

  assign trial = {rem, quo[31]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= A_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      case (state)
        A_IDLE: begin
          if (req.start) begin
            rsp.div_zero <= 1'b0;
            case (req.op)
              OP_ADD: begin
                result   <= a + b;
                rsp.done <= 1'b1;
              end
              OP_SUB: begin
                result   <= a - b;
                rsp.done <= 1'b1;
              end
              OP_MUL: begin
                result   <= a * b;
                rsp.done <= 1'b1;
              end
              OP_DIV: begin
                if (b == 32'd0) begin
                  result       <= 32'd0;
                  rsp.div_zero <= 1'b1;
                  rsp.done     <= 1'b1;
                end else begin
                  quo   <= a[31] ? (~a + 32'd1) : a;
                  dvs   <= b[31] ? (~b + 32'd1) : b;
                  rem   <= 32'd0;
                  neg   <= a[31] ^ b[31];
                  step  <= 5'd0;
                  state <= A_DIV;
                end
              end
              default: begin
                result   <= 32'd0;
                rsp.done <= 1'b1;
              end
            endcase
          end
        end
        A_DIV: begin
          if (!diff[32]) begin
            rem <= diff[31:0];
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= trial[31:0];
            quo <= {quo[30:0], 1'b0};
          end
          step <= step + 5'd1;
          if (step == 5'd31) begin
            state <= A_FIX;
          end
        end
        A_FIX: begin
          result   <= neg ? (~quo + 32'd1) : quo;
          rsp.done <= 1'b1;
          state    <= A_IDLE;
        end
        default: begin
          state <= A_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/postfix_expression_evaluator.sv -----
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Evaluates postfix expressions one character per transfer on a bounded
// operand stack and returns the top of the stack after the last character.
// ----------------------------------------------------------------------------
// One character is taken per transfer and the block stalls its input until
// that character is done. An operand is pushed directly; +, - or * pops two
// operands through the stack reads, starts the arithmetic unit, waits for it
// and pushes its result. A division waits on the divider, which produces one
// quotient bit per cycle; a division by zero skips the divider.
// The character marked as the end of the expression then loads the result
// register, after any time the result register is still held by an earlier
// result that has not been taken.
module postfix_expression_evaluator
  import pfx_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    sym_valid,
  output logic    sym_stall,
  input  sym_t    sym,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP1,
    S_POP2,
    S_LOAD,
    S_START,
    S_WAIT,
    S_PUSH,
    S_EMIT
  } state_t;

  state_t      state;
  logic [CNT_W-1:0] count;
  logic        last;
  alu_op_t     op;
  logic        pop1_ok;
  logic        pop2_ok;
  logic [31:0] lhs;
  logic [31:0] rhs;
  logic [31:0] res;
  logic [31:0] top;
  logic        flag_under;
  logic        flag_over;
  logic        flag_divz;

  logic        ram_we;
  logic [31:0] ram_rdata;
  logic        full;
  alu_req_t    alu_req;
  alu_rsp_t    alu_rsp;
  logic [31:0] alu_result;

  assign full        = (count == CNT_W'(STACK_DEPTH));
  assign ram_we      = (state == S_PUSH) && !full;
  assign sym_stall   = (state != S_IDLE);
  assign alu_req.start = (state == S_START);
  assign alu_req.op  = op;

  pfx_stack_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[ADDR_W-1:0]),
    .wdata (res),
    .raddr (ADDR_W'(count - CNT_W'(1))),
    .rdata (ram_rdata)
  );

  pfx_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .a      (lhs),
    .b      (rhs),
    .rsp    (alu_rsp),
    .result (alu_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      flag_under   <= 1'b0;
      flag_over    <= 1'b0;
      flag_divz    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && state != S_EMIT) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (sym_valid) begin
            last <= sym.end_of_expr;
            case (sym.symbol)
              CH_PLUS: begin
                op    <= OP_ADD;
                state <= S_POP1;
              end
              CH_MINUS: begin
                op    <= OP_SUB;
                state <= S_POP1;
              end
              CH_STAR: begin
                op    <= OP_MUL;
                state <= S_POP1;
              end
              CH_SLASH: begin
                op    <= OP_DIV;
                state <= S_POP1;
              end
              default: begin
                res   <= {24'd0, sym.symbol} - {24'd0, CH_ZERO};
                state <= S_PUSH;
              end
            endcase
          end
        end
        S_POP1: begin
          if (count == '0) begin
            pop1_ok    <= 1'b0;
            flag_under <= 1'b1;
          end else begin
            pop1_ok <= 1'b1;
            count   <= count - CNT_W'(1);
          end
          state <= S_POP2;
        end
        S_POP2: begin
          rhs <= pop1_ok ? ram_rdata : '1;
          if (count == '0) begin
            pop2_ok    <= 1'b0;
            flag_under <= 1'b1;
          end else begin
            pop2_ok <= 1'b1;
            count   <= count - CNT_W'(1);
          end
          state <= S_LOAD;
        end
        S_LOAD: begin
          lhs   <= pop2_ok ? ram_rdata : '1;
          state <= S_START;
        end
        S_START: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (alu_rsp.done) begin
            res <= alu_result;
            if (alu_rsp.div_zero) begin
              flag_divz <= 1'b1;
            end
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (full) begin
            flag_over <= 1'b1;
          end else begin
            top   <= res;
            count <= count + CNT_W'(1);
          end
          state <= last ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (!result_valid || !result_stall) begin
            result_valid          <= 1'b1;
            result.value          <= (count == '0) ? '1 : top;
            result.stack_empty    <= (count == '0);
            result.underflow_seen <= flag_under;
            result.overflow_seen  <= flag_over;
            result.div_zero_seen  <= flag_divz;
            count                 <= '0;
            flag_under            <= 1'b0;
            flag_over             <= 1'b0;
            flag_divz             <= 1'b0;
            state                 <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/pfx_checker.sv -----
// ----------------------------------------------------------------------------
// pfx_checker
// Port-level checks of the postfix expression evaluator, bound to its top.
// ----------------------------------------------------------------------------
module pfx_checker
  import pfx_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    sym_valid,
  input logic    sym_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // A stalled result transfer keeps its valid and its payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // Every accepted character keeps the input stalled in the next cycle.
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    sym_valid && !sym_stall |=> sym_stall)
    else $error("input not stalled after a transfer");

  // An empty stack reports the value minus one.
  a_empty_value: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.stack_empty |-> result.value == -32'sd1)
    else $error("empty stack result does not read minus one");

  // Reset leaves the block ready with no result pending.
  a_reset_state: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !sym_stall && !result_valid)
    else $error("block not idle after reset");

endmodule

bind postfix_expression_evaluator pfx_checker u_pfx_checker (
  .clk          (clk),
  .rst          (rst),
  .sym_valid    (sym_valid),
  .sym_stall    (sym_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

// ----- verif/postfix_expression_evaluator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_tb
// Self-checking testbench for the postfix expression evaluator. A queue of
// expression characters feeds a clocked driver, and a clocked monitor runs
// each accepted character through a stack model of its own and compares every
// result transfer with the oldest predicted result. Directed expressions
// cover the byte extremes, every operator, underflow, division by zero and
// the most negative value divided by -1. Random expressions then run under
// three mixes of sender and receiver idling, including a long receiver
// hold-off and stack overflow runs.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_tb;
  import pfx_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 60;

  logic    clk;
  logic    rst          = 1'b1;
  logic    sym_valid    = 1'b0;
  logic    sym_stall;
  sym_t    sym          = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  sym_t        char_queue[$];
  result_t     predicted_results[$];
  logic [31:0] model_stack[STACK_DEPTH];
  int          model_depth;
  logic        flag_under;
  logic        flag_over;
  logic        flag_divz;

  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  bit      hold_req      = 1'b0;
  int      hold_cnt      = 0;
  bit      in_taken      = 1'b0;
  int      items_queued  = 0;
  int      chars_sent    = 0;
  int      results_checked = 0;
  int      under_results = 0;
  int      over_results  = 0;
  int      divz_results  = 0;
  int      error_count   = 0;
  int      idle_cycles   = 0;
  result_t want;

  postfix_expression_evaluator dut (
    .clk          (clk),
    .rst          (rst),
    .sym_valid    (sym_valid),
    .sym_stall    (sym_stall),
    .sym          (sym),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_operator(logic [7:0] c);
    return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH;
  endfunction

  function automatic void model_push(logic [31:0] v);
    if (model_depth >= STACK_DEPTH) begin
      flag_over = 1'b1;
    end else begin
      model_stack[model_depth] = v;
      model_depth++;
    end
  endfunction

  function automatic logic [31:0] model_pop();
    if (model_depth == 0) begin
      flag_under = 1'b1;
      return 32'hFFFF_FFFF;
    end
    model_depth--;
    return model_stack[model_depth];
  endfunction

  function automatic void rpn_step(sym_t s);
    logic [31:0] lhs;
    logic [31:0] rhs;
    logic [31:0] r;
    longint      q;
    result_t     res;
    if (is_operator(s.symbol)) begin
      rhs = model_pop();
      lhs = model_pop();
      case (s.symbol)
        CH_PLUS:  r = lhs + rhs;
        CH_MINUS: r = lhs - rhs;
        CH_STAR:  r = lhs * rhs;
        default: begin
          if (rhs == 32'd0) begin
            flag_divz = 1'b1;
            r = 32'd0;
          end else begin
            q = longint'($signed(lhs)) / longint'($signed(rhs));
            r = 32'(q);
          end
        end
      endcase
      model_push(r);
    end else begin
      model_push({24'd0, s.symbol} - 32'd48);
    end
    if (s.end_of_expr) begin
      res.stack_empty    = (model_depth == 0);
      res.value          = (model_depth == 0) ? 32'hFFFF_FFFF : model_stack[model_depth - 1];
      res.underflow_seen = flag_under;
      res.overflow_seen  = flag_over;
      res.div_zero_seen  = flag_divz;
      predicted_results.push_back(res);
      model_depth = 0;
      flag_under  = 1'b0;
      flag_over   = 1'b0;
      flag_divz   = 1'b0;
    end
  endfunction

  task automatic check_field(string field, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d",
               $time, field, $signed(exp_v), $signed(got_v));
      error_count++;
    end
  endtask

  task automatic push_char(logic [7:0] c, bit last);
    char_queue.push_back('{symbol: c, end_of_expr: last});
    items_queued++;
  endtask

  function automatic logic [7:0] pick_operand();
    logic [7:0] c;
    if ($urandom_range(0, 4) != 0) begin
      return CH_ZERO + 8'($urandom_range(0, 9));
    end
    do c = 8'($urandom_range(0, 255)); while (is_operator(c));
    return c;
  endfunction

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(0, 3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  task automatic add_well_formed(int n_operands);
    int         pushed;
    int         depth;
    logic [7:0] c;
    pushed = 0;
    depth  = 0;
    while (!(pushed == n_operands && depth == 1)) begin
      if (pushed < n_operands && (depth < 2 || $urandom_range(0, 1) == 0)) begin
        c = pick_operand();
        pushed++;
        depth++;
      end else begin
        c = pick_operator();
        depth--;
      end
      push_char(c, pushed == n_operands && depth == 1);
    end
  endtask

  task automatic add_noise();
    int         len;
    logic [7:0] c;
    len = $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      c = ($urandom_range(0, 9) < 4) ? pick_operator() : 8'($urandom_range(0, 255));
      push_char(c, i == len - 1 || $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic add_overflow();
    int n_push;
    int n_ops;
    n_push = STACK_DEPTH + $urandom_range(1, 4);
    n_ops  = $urandom_range(0, 3);
    for (int i = 0; i < n_push; i++) begin
      push_char(pick_operand(), n_ops == 0 && i == n_push - 1);
    end
    for (int i = 0; i < n_ops; i++) begin
      push_char(pick_operator(), i == n_ops - 1);
    end
  endtask

  task automatic add_random_items(int target);
    int start;
    int pick;
    start = items_queued;
    while (items_queued - start < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        add_well_formed($urandom_range(1, 8));
      end else if (pick < 98) begin
        add_noise();
      end else begin
        add_overflow();
      end
    end
  endtask

  task automatic wait_drained();
    while (char_queue.size() != 0 || sym_valid) @(posedge clk);
    while (predicted_results.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      sym_valid <= 1'b0;
    end else if (!sym_valid || in_taken) begin
      in_taken = 1'b0;
      if (char_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        sym       <= char_queue.pop_front();
        sym_valid <= 1'b1;
      end else begin
        sym_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = LONG_HOLD;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (predicted_results.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual value %0d",
                   $time, result.value);
          error_count++;
        end else begin
          want = predicted_results.pop_front();
          check_field("value", want.value, result.value);
          check_field("stack_empty", want.stack_empty, result.stack_empty);
          check_field("underflow_seen", want.underflow_seen, result.underflow_seen);
          check_field("overflow_seen", want.overflow_seen, result.overflow_seen);
          check_field("div_zero_seen", want.div_zero_seen, result.div_zero_seen);
          results_checked++;
          under_results += want.underflow_seen;
          over_results  += want.overflow_seen;
          divz_results  += want.div_zero_seen;
        end
      end
      if (sym_valid && !sym_stall) begin
        rpn_step(sym);
        in_taken = 1'b1;
        chars_sent++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (sym_valid && !sym_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $time, idle_cycles);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    model_depth = 0;
    flag_under  = 1'b0;
    flag_over   = 1'b0;
    flag_divz   = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 24;
    recv_idle_pct = 83;
    push_char(8'd0, 1'b1);
    push_char(8'd255, 1'b1);
    push_char(CH_PLUS, 1'b1);
    push_char(CH_ZERO + 8'd128, 1'b0);
    push_char(CH_ZERO + 8'd128, 1'b0);
    push_char(CH_STAR, 1'b0);
    push_char(CH_ZERO + 8'd128, 1'b0);
    push_char(CH_STAR, 1'b0);
    push_char(CH_ZERO + 8'd128, 1'b0);
    push_char(CH_STAR, 1'b0);
    push_char(CH_ZERO + 8'd8, 1'b0);
    push_char(CH_STAR, 1'b0);
    push_char(CH_ZERO, 1'b0);
    push_char(CH_ZERO + 8'd1, 1'b0);
    push_char(CH_MINUS, 1'b0);
    push_char(CH_SLASH, 1'b1);
    push_char(CH_ZERO + 8'd5, 1'b0);
    push_char(CH_ZERO, 1'b0);
    push_char(CH_SLASH, 1'b1);
    push_char(CH_ZERO, 1'b0);
    push_char(CH_ZERO + 8'd7, 1'b0);
    push_char(CH_MINUS, 1'b0);
    push_char(CH_ZERO + 8'd2, 1'b0);
    push_char(CH_SLASH, 1'b1);
    add_random_items(600);
    wait_drained();

    send_idle_pct = 83;
    recv_idle_pct = 24;
    add_random_items(620);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b1;
    add_random_items(610);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d characters and checked %0d results under three idle mixes.",
             chars_sent, results_checked);
    $display("Results with underflow %0d, overflow %0d, divide by zero %0d.",
             under_results, over_results, divz_results);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/pfx_pkg.sv
hw/rtl/pfx_stack_ram.sv
hw/rtl/pfx_alu.sv
hw/rtl/postfix_expression_evaluator.sv
hw/rtl/pfx_checker.sv
verif/postfix_expression_evaluator_tb.sv
